[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the string solver RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wss_pkg.sv]
// ---------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the vibrating string solver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wss_pkg;

	localparam int DEF_MAX_POINTS  = 1024;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int IDX_BITS        = 10;
	localparam int REQ_BITS        = 2;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_IDX_BITS    = 1;
	localparam int R2_BITS         = 32;
	localparam int NPTS_BITS       = 11;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [R2_BITS-1:0]   R2_RESET   = 32'd27;
	localparam logic [NPTS_BITS-1:0] NPTS_RESET = 11'd1000;

	// request codes on the input port
	typedef enum logic [REQ_BITS-1:0] {
		REQ_LOAD = 2'd0,
		REQ_STEP = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	// classified command handed from front to back
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_STEP = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_COURANT = 1'b0,
		CFG_POINTS  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'd0,
		ST_IDLE  = 3'd1,
		ST_READ  = 3'd2,
		ST_RUN   = 3'd3,
		ST_DRAIN = 3'd4
	} back_state_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} req_ctl_t;

endpackage

[rtl/wss_ram.sv]
// ---------------------------------------------------------------------------
// wss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wss_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/wss_front.sv]
// ---------------------------------------------------------------------------
// wss_front
// Request intake: classifies each request and queues it for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wss_front #(
	parameter int MAX_POINTS  = wss_pkg::DEF_MAX_POINTS,
	parameter int SAMPLE_BITS = wss_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [wss_pkg::REQ_BITS-1:0]         req_type,
	input  logic [wss_pkg::IDX_BITS-1:0]         point_index,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  logic [$clog2(MAX_POINTS+1)-1:0]      line_len,
	input  logic                                 hold,
	output wss_pkg::req_ctl_t                    req_ctl,
	output logic [wss_pkg::IDX_BITS-1:0]         req_idx,
	output logic signed [SAMPLE_BITS-1:0]        req_sample,
	input  logic                                 req_pop
);
	import wss_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t                    cmd_q  [QUEUE_DEPTH];
	logic [IDX_BITS-1:0]     idx_q  [QUEUE_DEPTH];
	logic [SAMPLE_BITS-1:0]  smp_q  [QUEUE_DEPTH];
	logic [QPW-1:0]          wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]          cnt_q;
	cmd_t                    cmd_c;
	logic                    in_range;
	logic                    accept;
	logic                    take;

	// classify: out-of-range loads and reads, and unknown codes, do nothing
	assign in_range = 32'(point_index) < 32'(line_len);

	always_comb begin
		case (req_t'(req_type))
			REQ_LOAD: cmd_c = in_range ? CMD_LOAD : CMD_NOP;
			REQ_STEP: cmd_c = CMD_STEP;
			REQ_READ: cmd_c = in_range ? CMD_READ : CMD_NOP;
			default:  cmd_c = CMD_NOP;
		endcase
	end

	assign full   = (cnt_q == QCW'(QUEUE_DEPTH)) || hold;
	assign accept = push && !full;
	assign take   = req_pop && (cnt_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q[wr_ptr_q] <= cmd_c;
			idx_q[wr_ptr_q] <= point_index;
			smp_q[wr_ptr_q] <= sample_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign req_ctl.valid = (cnt_q != '0);
	assign req_ctl.cmd   = cmd_q[rd_ptr_q];
	assign req_idx       = idx_q[rd_ptr_q];
	assign req_sample    = $signed(smp_q[rd_ptr_q]);

endmodule

[rtl/wss_back.sv]
// ---------------------------------------------------------------------------
// wss_back
// Execution unit: line memories, step sweep pipeline and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wss_back #(
	parameter int MAX_POINTS  = wss_pkg::DEF_MAX_POINTS,
	parameter int SAMPLE_BITS = wss_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [wss_pkg::R2_BITS-1:0]      courant,
	input  logic [$clog2(MAX_POINTS+1)-1:0]  line_len,
	input  wss_pkg::req_ctl_t                req_ctl,
	input  logic [wss_pkg::IDX_BITS-1:0]     req_idx,
	input  logic signed [SAMPLE_BITS-1:0]    req_sample,
	output logic                             req_pop,
	output logic                             clearing,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [SAMPLE_BITS-1:0]    sample_out,
	output logic                             overflow
);
	import wss_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int SB = SAMPLE_BITS;
	localparam int LW = SB + 3;
	localparam int MW = LW + 17;
	localparam int PW = LW + 18;

	localparam logic signed [PW-1:0] SAT_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [PW-1:0] HALF_FULL  = PW'(32768);
	localparam logic signed [PW-1:0] HALF_START = PW'(65536);

	back_state_t state_q, state_d;

	logic [AW-1:0]  clr_ptr_q, k_q, req_addr;
	logic           started_q, ovf_q;
	logic           res_valid_q, res_ovf_q;
	logic [SB-1:0]  res_sample_q;
	logic           res_set, res_set_ovf;
	logic [SB-1:0]  res_set_sample;
	logic           issue, step_start, step_done, load_done, last_k, pipe_busy;

	// memory ports
	logic           pres_we;
	logic [AW-1:0]  pres_waddr, pres_raddr;
	logic [SB-1:0]  pres_wdata, pres_rdata, past_rdata;

	// sweep pipeline
	logic                 d_v_q;
	logic [AW-1:0]        d_k_q;
	logic signed [SB-1:0] p1_q, p2_q, pp1_q;
	logic                 v_s1, v_s2, v_s3;
	logic signed [LW-1:0] lap_s1;
	logic signed [SB-1:0] cur_s1, past_s1, cur_s2, past_s2, nv_s3;
	logic [AW-1:0]        addr_s1, addr_s2, addr_s3;
	logic signed [MW-1:0] hi_s2, lo_s2;
	logic signed [PW-1:0] q_c, sum_c, scaled_c, nv_c, cur_ext, past_ext;
	logic signed [SB-1:0] sat_val_c;
	logic                 sat_c;

	wss_ram #(.WIDTH(SB), .DEPTH(MAX_POINTS)) u_cur_line (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (pres_raddr),
		.rdata (pres_rdata)
	);

	// past line: every point gets the old present value as it streams by
	wss_ram #(.WIDTH(SB), .DEPTH(MAX_POINTS)) u_past (
		.clk   (clk),
		.we    (d_v_q),
		.waddr (d_k_q),
		.wdata (pres_rdata),
		.raddr (k_q),
		.rdata (past_rdata)
	);

	assign req_addr  = AW'(32'(req_idx));
	assign last_k    = 32'(k_q) == 32'(line_len) - 32'd1;
	assign pipe_busy = d_v_q || v_s1 || v_s2 || v_s3;
	assign clearing  = (state_q == ST_CLEAR);

	// sequencer: next state and memory port control
	always_comb begin
		state_d        = state_q;
		req_pop        = 1'b0;
		pres_we        = v_s3;
		pres_waddr     = addr_s3;
		pres_wdata     = nv_s3;
		pres_raddr     = k_q;
		res_set        = 1'b0;
		res_set_sample = '0;
		res_set_ovf    = 1'b0;
		issue          = 1'b0;
		step_start     = 1'b0;
		step_done      = 1'b0;
		load_done      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				pres_we    = 1'b1;
				pres_waddr = clr_ptr_q;
				pres_wdata = '0;
				if (clr_ptr_q == AW'(MAX_POINTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_ctl.valid && !res_valid_q) begin
					req_pop = 1'b1;
					case (req_ctl.cmd)
						CMD_LOAD: begin
							pres_we    = 1'b1;
							pres_waddr = req_addr;
							pres_wdata = req_sample;
							load_done  = 1'b1;
							res_set    = 1'b1;
						end
						CMD_READ: begin
							pres_raddr = req_addr;
							state_d    = ST_READ;
						end
						CMD_STEP: begin
							if (line_len == '0) begin
								step_done = 1'b1;
								res_set   = 1'b1;
							end else begin
								step_start = 1'b1;
								state_d    = ST_RUN;
							end
						end
						default: begin
							res_set = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_set        = 1'b1;
				res_set_sample = pres_rdata;
				state_d        = ST_IDLE;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					res_set     = 1'b1;
					res_set_ovf = ovf_q;
					step_done   = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_ptr_q   <= '0;
			k_q         <= '0;
			started_q   <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			d_v_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (step_start) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (load_done) begin
				started_q <= 1'b0;
			end else if (step_done) begin
				started_q <= 1'b1;
			end
			if (step_start) begin
				ovf_q <= 1'b0;
			end else if (v_s2 && sat_c) begin
				ovf_q <= 1'b1;
			end
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			d_v_q <= issue;
			v_s1  <= d_v_q && (32'(d_k_q) >= 32'd2);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
		end
	end

	// window of three neighbors and Laplacian
	always_ff @(posedge clk) begin
		d_k_q <= k_q;
		if (d_v_q) begin
			p2_q  <= p1_q;
			p1_q  <= $signed(pres_rdata);
			pp1_q <= $signed(past_rdata);
		end
		lap_s1  <= LW'($signed(pres_rdata)) - (LW'(p1_q) <<< 1) + LW'(p2_q);
		cur_s1  <= p1_q;
		past_s1 <= pp1_q;
		addr_s1 <= d_k_q - 1'b1;
	end

	// partial products of Laplacian times r squared
	always_ff @(posedge clk) begin
		hi_s2   <= lap_s1 * $signed({1'b0, courant[31:16]});
		lo_s2   <= lap_s1 * $signed({1'b0, courant[15:0]});
		cur_s2  <= cur_s1;
		past_s2 <= past_s1;
		addr_s2 <= addr_s1;
	end

	// rounding, update formula and saturation
	always_comb begin
		cur_ext  = PW'(cur_s2);
		past_ext = PW'(past_s2);
		q_c      = PW'(lo_s2) >>> 16;
		sum_c    = PW'(hi_s2) + q_c + (started_q ? HALF_FULL : HALF_START);
		scaled_c = started_q ? (sum_c >>> 16) : (sum_c >>> 17);
		nv_c     = started_q ? ((cur_ext <<< 1) - past_ext + scaled_c) : (cur_ext + scaled_c);
		sat_c    = 1'b0;
		if (nv_c > SAT_MAX) begin
			sat_val_c = SAT_MAX[SB-1:0];
			sat_c     = 1'b1;
		end else if (nv_c < SAT_MIN) begin
			sat_val_c = SAT_MIN[SB-1:0];
			sat_c     = 1'b1;
		end else begin
			sat_val_c = nv_c[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		nv_s3   <= sat_val_c;
		addr_s3 <= addr_s2;
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_set) begin
			res_sample_q <= res_set_sample;
			res_ovf_q    <= res_set_ovf;
		end
	end

	assign empty      = !res_valid_q;
	assign sample_out = $signed(res_sample_q);
	assign overflow   = res_ovf_q;

	`CHK_IMPLY(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !v_s3 && !v_s2, "sweep write during clear")
	`CHK_IMPLY(a_pop_idle, clk, arst_n, req_pop, (state_q == ST_IDLE) && !res_valid_q, "request taken while busy")
	`CHK_NEXT(a_drain_done, clk, arst_n, (state_q == ST_DRAIN) && !pipe_busy, res_valid_q && (state_q == ST_IDLE), "step result missing")

endmodule

[rtl/wave_string_step.sv]
// ---------------------------------------------------------------------------
// wave_string_step
// Leapfrog finite-difference solver for a vibrating string.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue port (push/full) and each produces exactly
//   one result on a queue port (empty/pop). Request types: load a sample into
//   the present line, advance all interior points one time step, read a sample.
//   A two-entry request queue lets requests be taken while a result waits.
//   The back end runs requests one at a time and takes a new one only after
//   it is through with the last.
//   A new request starts only after the previous result has left the result
//   register, so a stalled receiver stalls the back end and then fills the
//   request queue, raising full.
//   After reset all MAX_POINTS entries of the present line are cleared, during
//   which full stays high; configuration writes are taken at any time
//   but must only be made while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_string_step #(
	parameter int MAX_POINTS  = wss_pkg::DEF_MAX_POINTS,
	parameter int SAMPLE_BITS = wss_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [wss_pkg::REQ_BITS-1:0]        req_type,
	input  logic [wss_pkg::IDX_BITS-1:0]        point_index,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic                                overflow
);
	import wss_pkg::*;

	localparam int NW = $clog2(MAX_POINTS + 1);

	logic [R2_BITS-1:0]     courant_q;
	logic [NPTS_BITS-1:0]   points_q;
	logic [NW-1:0]          line_len;
	req_ctl_t               req_ctl;
	logic [IDX_BITS-1:0]    req_idx;
	logic signed [SAMPLE_BITS-1:0] req_sample;
	logic                   req_pop;
	logic                   clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= R2_RESET;
			points_q  <= NPTS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_COURANT: courant_q <= cfg_data[R2_BITS-1:0];
				CFG_POINTS:  points_q  <= cfg_data[NPTS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// line length clamped to the memory depth
	always_comb begin
		if (32'(points_q) > 32'(MAX_POINTS)) begin
			line_len = NW'(MAX_POINTS);
		end else begin
			line_len = NW'(points_q);
		end
	end

	wss_front #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.point_index (point_index),
		.sample_in   (sample_in),
		.line_len    (line_len),
		.hold        (clearing),
		.req_ctl     (req_ctl),
		.req_idx     (req_idx),
		.req_sample  (req_sample),
		.req_pop     (req_pop)
	);

	wss_back #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.courant    (courant_q),
		.line_len   (line_len),
		.req_ctl    (req_ctl),
		.req_idx    (req_idx),
		.req_sample (req_sample),
		.req_pop    (req_pop),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.overflow   (overflow)
	);

endmodule
